// ----- src/tbh_pkg.sv -----
package tbh_pkg;

	localparam int SPEED_W = 16;
	localparam int TARGET_W = 15;
	localparam int GAIN_W = 16;
	localparam int ERROR_W = 17;
	localparam int DRIVE_W = 31;
	localparam int PRODUCT_W = 34;
	localparam int MV_W = 14;
	localparam int PERCENT_W = 15;
	localparam int CFG_DATA_W = 16;

	// Full scale drive is 100 percent in units of 2^-24 percent.
	localparam logic [DRIVE_W-1:0] DRIVE_FULL_SCALE = 31'd1677721600;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1638;

	typedef enum logic [0:0] {
		REG_TARGET_SPEED = 1'b0,
		REG_INTEGRAL_GAIN = 1'b1
	} cfg_index_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic multiply;
		logic clamp;
		logic take_back;
		logic load_out;
	} dp_cmd_t;

endpackage

// ----- src/tbh_datapath.sv -----
module tbh_datapath
	import tbh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  cfg_index_t             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  dp_cmd_t                cmd,
	input  logic [SPEED_W-1:0]     measured_speed,
	output logic [MV_W-1:0]        drive_millivolts,
	output logic [PERCENT_W-1:0]   drive_percent
);

	logic [TARGET_W-1:0]         target_speed_q;
	logic [GAIN_W-1:0]           integral_gain_q;
	logic [SPEED_W-1:0]          speed_q;
	logic signed [ERROR_W-1:0]   err_c;
	logic signed [ERROR_W-1:0]   err_s1;
	logic signed [PRODUCT_W-1:0] product_s1;
	logic signed [PRODUCT_W:0]   sum_c;
	logic [DRIVE_W-1:0]          clamped_c;
	logic [DRIVE_W-1:0]          next_s2;
	logic [DRIVE_W:0]            avg_sum_c;
	logic [DRIVE_W-1:0]          avg_c;
	logic                        crossed_c;
	logic [DRIVE_W-1:0]          drive_level_q;
	logic [DRIVE_W-1:0]          take_back_q;
	logic signed [ERROR_W-1:0]   prev_err_q;
	logic [DRIVE_W+6:0]          mv_full_c;
	logic [MV_W-1:0]             mv_q;
	logic [PERCENT_W-1:0]        percent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q <= '0;
			integral_gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_SPEED:  target_speed_q <= cfg_data[TARGET_W-1:0];
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// The error always fits 17 bits, even for a target beyond full scale.
	assign err_c = $signed({2'b00, target_speed_q}) - $signed({speed_q[SPEED_W-1], speed_q});

	assign sum_c = $signed({{(PRODUCT_W + 1 - DRIVE_W){1'b0}}, drive_level_q})
		+ $signed({product_s1[PRODUCT_W-1], product_s1});

	always_comb begin
		if (sum_c < 0) begin
			clamped_c = '0;
		end else if (sum_c > $signed({{(PRODUCT_W + 1 - DRIVE_W){1'b0}}, DRIVE_FULL_SCALE})) begin
			clamped_c = DRIVE_FULL_SCALE;
		end else begin
			clamped_c = sum_c[DRIVE_W-1:0];
		end
	end

	assign crossed_c = (err_s1 > 0 && prev_err_q < 0) || (err_s1 < 0 && prev_err_q > 0);
	assign avg_sum_c = {1'b0, next_s2} + {1'b0, take_back_q};
	assign avg_c = avg_sum_c[DRIVE_W:1];

	// Times 120 as 128 minus 8.
	assign mv_full_c = {drive_level_q, 7'b0} - {4'b0, drive_level_q, 3'b0};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			speed_q <= measured_speed;
		end
		if (cmd.multiply) begin
			err_s1 <= err_c;
			product_s1 <= $signed({1'b0, integral_gain_q}) * err_c;
		end
		if (cmd.clamp) begin
			next_s2 <= clamped_c;
		end
		if (cmd.load_out) begin
			mv_q <= mv_full_c[DRIVE_W+6:24];
			percent_q <= drive_level_q[DRIVE_W-1:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_level_q <= '0;
			take_back_q <= '0;
			prev_err_q <= '0;
		end else if (cmd.take_back) begin
			drive_level_q <= crossed_c ? avg_c : next_s2;
			if (crossed_c) begin
				take_back_q <= avg_c;
			end
			prev_err_q <= err_s1;
		end
	end

	assign drive_millivolts = mv_q;
	assign drive_percent = percent_q;

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_level_q <= DRIVE_FULL_SCALE)
		else $error("drive level beyond full scale");

	a_take_back_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		take_back_q <= DRIVE_FULL_SCALE)
		else $error("take-back value beyond full scale");

endmodule

// ----- src/tbh_ctrl.sv -----
module tbh_ctrl
	import tbh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CLAMP,
		S_AVG,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign cmd.load_in = in_valid && in_ready;
	assign cmd.multiply = (state_q == S_MUL);
	assign cmd.clamp = (state_q == S_CLAMP);
	assign cmd.take_back = (state_q == S_AVG);
	assign cmd.load_out = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may be loaded in the same cycle the old one is taken.
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_AVG;
				S_AVG:   state_q <= S_OUT;
				S_OUT: begin
					// Wait here while the previous result has not been taken.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_accept_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##4 (state_q == S_OUT))
		else $error("accepted sample did not reach the output step");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.multiply, cmd.clamp, cmd.take_back, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

endmodule

// ----- src/take_back_half_speed_controller.sv -----
// Take-back-half speed controller. Each transfer on the input channel is one
// measured speed sample (1/256 percent, signed); the block forms the error
// against target_speed, integrates integral_gain times the error into the
// drive level, clamps it to 0..100 percent and, when the error changes sign,
// averages the drive with the held take-back value. Each sample yields one
// result: drive in millivolts and in 1/256 percent. A sample is accepted in
// the idle state, runs through the multiply, clamp and take-back steps of
// the controller, and its result is loaded into the output register in the
// output step once that register is free. The next sample is accepted
// only after the controller returns to idle. A result waiting in the output
// register does not block the next sample's acceptance. Configuration writes
// are always accepted (index 0 is target_speed, index 1 is integral_gain)
// and must only be made while no sample is in flight.
module take_back_half_speed_controller
	import tbh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SPEED_W-1:0]    measured_speed,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MV_W-1:0]       drive_millivolts,
	output logic [PERCENT_W-1:0]  drive_percent
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	tbh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tbh_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index_t'(cfg_index)),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.measured_speed   (measured_speed),
		.drive_millivolts (drive_millivolts),
		.drive_percent    (drive_percent)
	);

endmodule

// ----- sim/take_back_half_speed_controller_test.sv -----
module take_back_half_speed_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tbh_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int MV_PER_PERCENT = 120;
	localparam int PHASE_ITEMS = 200;
	localparam int RANDOM_PHASES = 8;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [MV_W-1:0]      mv;
		logic [PERCENT_W-1:0] pct;
	} drive_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = REG_TARGET_SPEED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SPEED_W-1:0]    measured_speed = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [MV_W-1:0]       drive_millivolts;
	logic [PERCENT_W-1:0]  drive_percent;

	take_back_half_speed_controller u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.measured_speed   (measured_speed),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.drive_millivolts (drive_millivolts),
		.drive_percent    (drive_percent)
	);

	initial forever #1 clk = ~clk;

	// Controller state as the testbench sees it.
	logic [TARGET_W-1:0] set_target = '0;
	logic [GAIN_W-1:0]   set_gain = GAIN_RESET;
	logic [DRIVE_W-1:0]  drive_acc = '0;
	logic [DRIVE_W-1:0]  held_drive = '0;
	int                  last_error = 0;

	logic [SPEED_W-1:0] speed_backlog[$];
	drive_result_t      drive_expected[$];

	int unsigned fail_count = 0;
	int unsigned sent_count = 0;
	int unsigned received_count = 0;
	int unsigned send_gap = 0;
	int unsigned ready_gap = 0;
	int unsigned hold_left = 0;

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void predict_drive(input logic [SPEED_W-1:0] speed);
		int            err;
		longint        next;
		longint        mv_full;
		bit            crossed;
		drive_result_t r;
		err = int'(set_target) - int'($signed(speed));
		next = longint'(drive_acc) + longint'(set_gain) * longint'(err);
		if (next > longint'(DRIVE_FULL_SCALE))
			next = longint'(DRIVE_FULL_SCALE);
		if (next < 0)
			next = 0;
		// Take back half only on a strict sign change; zero on either side does not count.
		crossed = (err > 0 && last_error < 0) || (err < 0 && last_error > 0);
		if (crossed) begin
			next = (next + longint'(held_drive)) >>> 1;
			held_drive = next[DRIVE_W-1:0];
		end
		drive_acc = next[DRIVE_W-1:0];
		last_error = err;
		mv_full = (longint'(drive_acc) * MV_PER_PERCENT) >>> 24;
		r.mv = mv_full[MV_W-1:0];
		r.pct = drive_acc[16 +: PERCENT_W];
		drive_expected.push_back(r);
	endfunction

	// Sender: one speed sample per transfer, fed from the backlog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_drive(measured_speed);
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (speed_backlog.size() > 0) begin
					in_valid <= 1'b1;
					measured_speed <= speed_backlog.pop_front();
					send_gap = pick_gap(((sent_count / 64) % 4) == 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and throttles out_ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				received_count++;
				if (drive_expected.size() == 0) begin
					$display("%0t: unexpected result mv=%0d pct=%0d", $time,
						drive_millivolts, drive_percent);
					fail_count++;
				end else begin
					drive_result_t exp_r;
					exp_r = drive_expected.pop_front();
					if (drive_millivolts !== exp_r.mv) begin
						$display("%0t: drive_millivolts expected %0d got %0d", $time,
							exp_r.mv, drive_millivolts);
						fail_count++;
					end
					if (drive_percent !== exp_r.pct) begin
						$display("%0t: drive_percent expected %0d got %0d", $time,
							exp_r.pct, drive_percent);
						fail_count++;
					end
				end
				// Long back-pressure so the block fills and stalls its input.
				if (received_count == 300 || received_count == 900)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				ready_gap = pick_gap(((received_count / 50) % 4) == 1);
			end
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TARGET_SPEED)
			set_target = data[TARGET_W-1:0];
		else
			set_gain = data;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (speed_backlog.size() != 0 || in_valid || drive_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_near_target(input int unsigned count);
		int          delta;
		int unsigned w;
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 2))
				0: w = 8;
				1: w = 300;
				default: w = 5000;
			endcase
			delta = int'($urandom_range(0, 2 * w)) - int'(w);
			if (r < 10)
				speed_backlog.push_back(SPEED_W'(set_target));
			else if (r < 80)
				speed_backlog.push_back(SPEED_W'(int'(set_target) + delta));
			else
				speed_backlog.push_back(SPEED_W'($urandom));
		end
	endtask

	initial begin
		logic [SPEED_W-1:0] dir_a[8] = '{16'h0000, 16'h8000, 16'h8000, 16'h7FFF,
			16'h0000, 16'h7FFF, 16'hFFFF, 16'h0001};
		logic [SPEED_W-1:0] dir_b[8] = '{16'h8000, 16'h8000, 16'h8000, 16'h6400,
			16'h7FFF, 16'h8000, 16'h6401, 16'h63FF};
		logic [SPEED_W-1:0] dir_c[6] = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
			16'h7FFE, 16'hFFFF};
		logic [SPEED_W-1:0] dir_d[4] = '{16'h3200, 16'h3300, 16'h3100, 16'h3300};
		logic [TARGET_W-1:0] tgt;
		logic [GAIN_W-1:0]   gain;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: full reverse and forward speeds, zero errors, sign flips.
		@(negedge clk);
		foreach (dir_a[i]) speed_backlog.push_back(dir_a[i]);
		wait_idle();

		// Target at 100 percent, largest gain: drive clamps at full scale.
		write_reg(REG_TARGET_SPEED, 16'd25600);
		write_reg(REG_INTEGRAL_GAIN, 16'hFFFF);
		@(negedge clk);
		foreach (dir_b[i]) speed_backlog.push_back(dir_b[i]);
		wait_idle();

		// Target beyond 100 percent with bit 15 of the data set, zero gain.
		write_reg(REG_TARGET_SPEED, 16'hFFFF);
		write_reg(REG_INTEGRAL_GAIN, 16'h0000);
		@(negedge clk);
		foreach (dir_c[i]) speed_backlog.push_back(dir_c[i]);
		wait_idle();

		write_reg(REG_TARGET_SPEED, 16'd12800);
		write_reg(REG_INTEGRAL_GAIN, 16'd1);
		@(negedge clk);
		foreach (dir_d[i]) speed_backlog.push_back(dir_d[i]);
		wait_idle();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k % 4)
				0: tgt = '0;
				1: tgt = 15'd25600;
				2: tgt = '1;
				default: tgt = TARGET_W'($urandom_range(0, 32767));
			endcase
			case ((k / 2) % 4)
				0: gain = '1;
				1: gain = GAIN_W'($urandom);
				2: gain = '0;
				default: gain = GAIN_W'($urandom_range(1, 4000));
			endcase
			write_reg(REG_TARGET_SPEED, {1'($urandom), tgt});
			write_reg(REG_INTEGRAL_GAIN, gain);
			@(negedge clk);
			queue_near_target(PHASE_ITEMS);
			wait_idle();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (drive_expected.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				drive_expected.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
